### hw/rtl/l4pc_pkg.sv
// ----------------------------------------------------------------------------
// l4pc_pkg
// Shared types and constants for the layer-4 port priority classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package l4pc_pkg;

  localparam int MAX_PORTS   = 10;
  localparam int PORT_W      = 16;
  localparam int PORT_CNT_W  = 4;
  localparam int OFFSET_W    = 7;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_LSB = 3;

  // header layout
  localparam logic [OFFSET_W-1:0] MAC_LAST    = 7'd13;
  localparam logic [OFFSET_W-1:0] OFF_PROTO   = 7'd9;
  localparam logic [OFFSET_W-1:0] OFF_SRC_HI  = 7'd20;
  localparam logic [OFFSET_W-1:0] OFF_SRC_LO  = 7'd21;
  localparam logic [OFFSET_W-1:0] OFF_DST_HI  = 7'd22;
  localparam logic [OFFSET_W-1:0] OFF_DST_LO  = 7'd23;
  // last byte of udp + vxlan + inner mac header
  localparam logic [OFFSET_W-1:0] TUNNEL_LAST = 7'd49;

  localparam logic [7:0]        PROTO_TCP       = 8'd6;
  localparam logic [7:0]        PROTO_UDP       = 8'd17;
  localparam logic [PORT_W-1:0] TUNNEL_UDP_PORT = 16'd4789;

  // configuration register indexes
  localparam logic [1:0] REG_PORT_COUNT = 2'd0;
  localparam logic [1:0] REG_TABLE_A    = 2'd1;
  localparam logic [1:0] REG_TABLE_B    = 2'd2;
  localparam logic [1:0] REG_TABLE_C    = 2'd3;

  typedef logic [MAX_PORTS-1:0][PORT_W-1:0] port_table_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic high_priority;
    logic truncated;
  } out_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                in_ip;
    logic [7:0]          protocol;
    logic [PORT_W-1:0]   src_port;
    logic [PORT_W-1:0]   dst_port;
    logic                done;
    logic                value;
  } parse_state_t;

endpackage

`default_nettype wire

### hw/rtl/l4pc_port_match.sv
// ----------------------------------------------------------------------------
// l4pc_port_match
// Parallel compare of one port against the enabled priority table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module l4pc_port_match (
  input  wire logic [l4pc_pkg::PORT_W-1:0]     port,
  input  wire logic [l4pc_pkg::PORT_CNT_W-1:0] port_count,
  input  wire l4pc_pkg::port_table_t           ports,
  output logic                                 hit
);
  import l4pc_pkg::*;

  // entries at or above port_count are disabled; the loop bound caps the count
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      if ((PORT_CNT_W'(i) < port_count) && (ports[i] == port)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/l4pc_parser.sv
// ----------------------------------------------------------------------------
// l4pc_parser
// Per-byte header walk with vxlan restart and the end-of-frame verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module l4pc_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire l4pc_pkg::in_item_t              item,
  input  wire logic [l4pc_pkg::PORT_CNT_W-1:0] port_count,
  input  wire l4pc_pkg::port_table_t           ports,
  output l4pc_pkg::out_item_t                  result
);
  import l4pc_pkg::*;

  parse_state_t      state_r;
  parse_state_t      state_nxt;
  parse_state_t      work;
  logic [PORT_W-1:0] dst_full;
  logic              dst_hit;
  logic              src_hit;

  assign dst_full = {state_r.dst_port[PORT_W-1:8], item.data_byte};

  l4pc_port_match u_dst_match (
    .port       (dst_full),
    .port_count (port_count),
    .ports      (ports),
    .hit        (dst_hit)
  );

  l4pc_port_match u_src_match (
    .port       (state_r.src_port),
    .port_count (port_count),
    .ports      (ports),
    .hit        (src_hit)
  );

  always_comb begin
    work = state_r;
    if (!state_r.done) begin
      if (!state_r.in_ip) begin
        if (state_r.offset >= MAC_LAST) begin
          work.in_ip  = 1'b1;
          work.offset = '0;
        end else begin
          work.offset = state_r.offset + 1'b1;
        end
      end else begin
        unique case (state_r.offset)
          OFF_PROTO: begin
            work.protocol = item.data_byte;
            if (item.data_byte != PROTO_TCP && item.data_byte != PROTO_UDP) begin
              work.done  = 1'b1;
              work.value = 1'b0;
            end else begin
              work.offset = state_r.offset + 1'b1;
            end
          end
          OFF_SRC_HI: begin
            work.src_port = {item.data_byte, 8'h00};
            work.offset   = state_r.offset + 1'b1;
          end
          OFF_SRC_LO: begin
            work.src_port = {state_r.src_port[PORT_W-1:8], item.data_byte};
            work.offset   = state_r.offset + 1'b1;
          end
          OFF_DST_HI: begin
            work.dst_port = {item.data_byte, 8'h00};
            work.offset   = state_r.offset + 1'b1;
          end
          OFF_DST_LO: begin
            work.dst_port = dst_full;
            if (!(state_r.protocol == PROTO_UDP && dst_full == TUNNEL_UDP_PORT)) begin
              work.done  = 1'b1;
              work.value = dst_hit | src_hit;
            end else begin
              work.offset = state_r.offset + 1'b1;
            end
          end
          default: begin
            // end of the tunnel headers: inner ip header starts next byte
            if (state_r.offset >= TUNNEL_LAST) begin
              work.offset   = '0;
              work.protocol = '0;
              work.src_port = '0;
              work.dst_port = '0;
            end else begin
              work.offset = state_r.offset + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    result.high_priority = work.done & work.value;
    result.truncated     = ~work.done;
  end

  always_comb begin
    state_nxt = state_r;
    if (step) begin
      state_nxt = item.frame_end ? '0 : work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/l4_port_priority_classifier_unit.sv
// ----------------------------------------------------------------------------
// l4_port_priority_classifier_unit
// Byte-stream Ethernet classifier giving a priority verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle, unless stalled as below, and
// returns one verdict transaction on the out_ channel for each byte marked
// frame_end. A byte waits in the input register, where the header walk and
// the parallel compare against up to ten table ports run, and the verdict
// for a frame_end byte is registered in the output register. The input keeps
// flowing while a verdict waits in the output register; it stalls only when
// a frame_end byte finds that register still full. The port table and count
// sit at APB byte addresses 0, 8, 16, 24 with 64-bit data and should be
// written while no frame is in flight.
`default_nettype none

module l4_port_priority_classifier_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire l4pc_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output l4pc_pkg::out_item_t                    out_data,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [l4pc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [l4pc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [l4pc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import l4pc_pkg::*;

  logic [PORT_CNT_W-1:0] port_count_r;
  logic [63:0]           table_a_r;
  logic [63:0]           table_b_r;
  logic [31:0]           table_c_r;
  port_table_t           ports;
  logic [1:0]            reg_idx;
  logic                  cfg_wr;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      advance;
  out_item_t verdict;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_IDX_LSB+1:CFG_IDX_LSB];
  assign cfg_wr  = psel & penable & pwrite;
  assign ports   = {table_c_r, table_b_r, table_a_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_count_r <= '0;
      table_a_r    <= '0;
      table_b_r    <= '0;
      table_c_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PORT_COUNT: port_count_r <= pwdata[PORT_CNT_W-1:0];
        REG_TABLE_A:    table_a_r    <= pwdata;
        REG_TABLE_B:    table_b_r    <= pwdata;
        REG_TABLE_C:    table_c_r    <= pwdata[31:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PORT_COUNT: prdata = CFG_DATA_W'(port_count_r);
      REG_TABLE_A:    prdata = table_a_r;
      REG_TABLE_B:    prdata = table_b_r;
      REG_TABLE_C:    prdata = CFG_DATA_W'(table_c_r);
      default:        prdata = '0;
    endcase
  end

  // byte pipeline: input register -> parse -> verdict register
  assign out_free = ~out_valid_r | out_ready;
  assign advance  = in_valid_r & (~in_item_r.frame_end | out_free);
  assign in_ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  l4pc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (in_item_r),
    .port_count (port_count_r),
    .ports      (ports),
    .result     (verdict)
  );

  // a new verdict takes priority over draining the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_item_r.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item_r.frame_end) begin
      out_item_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

### tb/sv/tb_l4_port_priority_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_l4_port_priority_classifier_unit
// Feeds Ethernet frames byte by byte, with VXLAN nesting, truncation and
// noise, under random idling on both sides and several port table settings.
// Every verdict is checked against a header-walking predictor in the bench,
// or against the verdict typed into a directed row that pins one.

module tb_l4_port_priority_classifier_unit;
  import l4pc_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 240;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PHASE_BYTES   = 36;
  localparam int MAX_REPORTS   = 10;
  localparam int N_DIRECTED    = 20;

  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  tunnels;
    logic [7:0]  cut;      // 0 keeps the whole frame
    logic [3:0]  pay;
    logic        fixed;    // verdict below is typed in
    logic        hp;
    logic        tr;
  } frame_row_t;

  typedef struct packed {
    logic      fixed;
    out_item_t verdict;
  } pinned_verdict_t;

  // table used by the directed frames: ports 0..9 are
  // 0050 01bb ffff 0016 0000 0035 0d3d 1f90 c350 2328
  localparam frame_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{PROTO_TCP, 16'h0050, 16'h0050, 2'd0, 8'd1,  4'd0,  1'b1, 1'b0, 1'b1},
    '{PROTO_TCP, 16'h1111, 16'h0050, 2'd0, 8'd0,  4'd2,  1'b1, 1'b1, 1'b0},
    '{PROTO_UDP, 16'h2328, 16'h1234, 2'd0, 8'd0,  4'd0,  1'b1, 1'b1, 1'b0},
    '{PROTO_TCP, 16'h1111, 16'h2222, 2'd0, 8'd0,  4'd3,  1'b1, 1'b0, 1'b0},
    '{8'h01,     16'h0050, 16'h0050, 2'd0, 8'd0,  4'd0,  1'b1, 1'b0, 1'b0},
    '{8'hFF,     16'h0050, 16'hFFFF, 2'd0, 8'd0,  4'd1,  1'b1, 1'b0, 1'b0},
    '{8'h00,     16'h01BB, 16'h0050, 2'd0, 8'd0,  4'd0,  1'b1, 1'b0, 1'b0},
    '{PROTO_TCP, 16'h4000, 16'hFFFF, 2'd1, 8'd0,  4'd0,  1'b1, 1'b1, 1'b0},
    '{PROTO_UDP, 16'h0000, 16'h7777, 2'd2, 8'd0,  4'd2,  1'b1, 1'b1, 1'b0},
    '{PROTO_TCP, 16'h0050, 16'h0050, 2'd1, 8'd40, 4'd0,  1'b1, 1'b0, 1'b1},
    '{PROTO_TCP, 16'h3333, 16'h12B5, 2'd0, 8'd0,  4'd0,  1'b1, 1'b0, 1'b0},
    '{PROTO_TCP, 16'h0050, 16'h0050, 2'd0, 8'd24, 4'd0,  1'b1, 1'b0, 1'b1},
    '{8'h2F,     16'h0050, 16'h0050, 2'd0, 8'd24, 4'd0,  1'b1, 1'b0, 1'b0},
    '{PROTO_TCP, 16'h1111, 16'h0D3D, 2'd0, 8'd38, 4'd0,  1'b1, 1'b1, 1'b0},
    '{PROTO_TCP, 16'h1111, 16'h0D3D, 2'd0, 8'd37, 4'd0,  1'b1, 1'b0, 1'b1},
    '{PROTO_UDP, 16'h1111, 16'h12B5, 2'd0, 8'd38, 4'd0,  1'b1, 1'b0, 1'b1},
    '{PROTO_TCP, 16'hC350, 16'h8888, 2'd0, 8'd0,  4'd15, 1'b1, 1'b1, 1'b0},
    '{PROTO_UDP, 16'h8888, 16'h1F90, 2'd1, 8'd0,  4'd1,  1'b0, 1'b0, 1'b0},
    '{PROTO_TCP, 16'h0016, 16'h0035, 2'd3, 8'd0,  4'd0,  1'b0, 1'b0, 1'b0},
    '{PROTO_TCP, 16'h0050, 16'h0050, 2'd0, 8'd14, 4'd0,  1'b1, 1'b0, 1'b1}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  l4_port_priority_classifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // shadow of the port table registers
  logic [3:0]  cfg_count = '0;
  logic [63:0] cfg_a     = '0;
  logic [63:0] cfg_b     = '0;
  logic [31:0] cfg_c     = '0;

  // predictor header walk state
  logic [OFFSET_W-1:0] hdr_off   = '0;
  logic                hdr_in_ip = 1'b0;
  logic [7:0]          hdr_proto = '0;
  logic [15:0]         hdr_src   = '0;
  logic [15:0]         hdr_dst   = '0;
  logic                hdr_done  = 1'b0;
  logic                hdr_hit   = 1'b0;

  out_item_t       verdict_q [$];
  pinned_verdict_t pin_q [$];
  logic [7:0]      frame_bytes [$];

  int  mismatches   = 0;
  int  parsed_bytes = 0;
  int  results_seen = 0;
  int  hold_req     = 0;
  bit  send_calm    = 1'b0;

  function automatic logic [15:0] table_entry(input int i);
    if (i < 4) return cfg_a[16*i +: 16];
    if (i < 8) return cfg_b[16*(i-4) +: 16];
    return cfg_c[16*((i-8) & 1) +: 16];
  endfunction

  function automatic bit port_listed(input logic [15:0] port);
    int n;
    n = cfg_count;
    if (n > MAX_PORTS) n = MAX_PORTS;
    for (int i = 0; i < n; i++)
      if (table_entry(i) == port) return 1'b1;
    return 1'b0;
  endfunction

  // returns 0 when the byte is past the verdict and ignored
  function automatic bit walk_header_byte(input logic [7:0] b);
    logic [OFFSET_W-1:0] off;
    off = hdr_off;
    if (hdr_done) return 1'b0;
    if (!hdr_in_ip) begin
      if (off >= MAC_LAST) begin
        hdr_in_ip = 1'b1;
        hdr_off   = '0;
      end else begin
        hdr_off = off + 1'b1;
      end
      return 1'b1;
    end
    if (off == OFF_PROTO) begin
      hdr_proto = b;
      if (b != PROTO_TCP && b != PROTO_UDP) begin
        hdr_done = 1'b1;
        hdr_hit  = 1'b0;
        return 1'b1;
      end
    end else if (off == OFF_SRC_HI) begin
      hdr_src = {b, 8'h00};
    end else if (off == OFF_SRC_LO) begin
      hdr_src[7:0] = b;
    end else if (off == OFF_DST_HI) begin
      hdr_dst = {b, 8'h00};
    end else if (off == OFF_DST_LO) begin
      hdr_dst[7:0] = b;
      if (!(hdr_proto == PROTO_UDP && hdr_dst == TUNNEL_UDP_PORT)) begin
        hdr_done = 1'b1;
        hdr_hit  = port_listed(hdr_dst) || port_listed(hdr_src);
        return 1'b1;
      end
    end else if (off >= TUNNEL_LAST) begin
      // inner ip header starts on the next byte
      hdr_off   = '0;
      hdr_proto = '0;
      hdr_src   = '0;
      hdr_dst   = '0;
      return 1'b1;
    end
    hdr_off = off + 1'b1;
    return 1'b1;
  endfunction

  // scoreboard: predict on input transactions, check output transactions
  out_item_t       sb_exp;
  pinned_verdict_t sb_pin;
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (walk_header_byte(in_data.data_byte)) parsed_bytes <= parsed_bytes + 1;
      if (in_data.frame_end) begin
        sb_exp.high_priority = hdr_done & hdr_hit;
        sb_exp.truncated     = ~hdr_done;
        if (pin_q.size() > 0) begin
          sb_pin = pin_q.pop_front();
          if (sb_pin.fixed) sb_exp = sb_pin.verdict;
        end
        verdict_q.push_back(sb_exp);
        hdr_off   = '0;
        hdr_in_ip = 1'b0;
        hdr_proto = '0;
        hdr_src   = '0;
        hdr_dst   = '0;
        hdr_done  = 1'b0;
        hdr_hit   = 1'b0;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (verdict_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("unexpected verdict transaction: high_priority=%0b truncated=%0b",
                   out_data.high_priority, out_data.truncated);
      end else begin
        sb_exp = verdict_q.pop_front();
        if (out_data.high_priority !== sb_exp.high_priority ||
            out_data.truncated !== sb_exp.truncated) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("verdict %0d mismatch: expected hp=%0b trunc=%0b, got hp=%0b trunc=%0b",
                     results_seen, sb_exp.high_priority, sb_exp.truncated,
                     out_data.high_priority, out_data.truncated);
        end
      end
    end
  end

  // result side: random ready gaps, calm stretches and one long hold-off
  int ready_gap = 0;
  int hold_left = 0;
  int hold_seen = 0;
  bit recv_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_ready && out_valid) begin
      if ($urandom_range(0, 11) == 0) recv_calm <= ~recv_calm;
      if (!recv_calm) begin
        ready_gap = $urandom_range(0, 18);
        if (ready_gap != 0) out_ready <= 1'b0;
      end
    end else if (!out_ready) begin
      if (ready_gap <= 1) begin
        out_ready <= 1'b1;
        ready_gap <= 0;
      end else begin
        ready_gap <= ready_gap - 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PORT_COUNT: cfg_count = value[3:0];
      REG_TABLE_A:    cfg_a     = value;
      REG_TABLE_B:    cfg_b     = value;
      REG_TABLE_C:    cfg_c     = value[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] count, input logic [63:0] a,
                            input logic [63:0] b, input logic [63:0] c);
    drain();
    cfg_write(REG_PORT_COUNT, count);
    cfg_write(REG_TABLE_A, a);
    cfg_write(REG_TABLE_B, b);
    cfg_write(REG_TABLE_C, c);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {b, last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // mac, then vxlan layers, then the ip header and l4 ports the verdict reads
  task automatic build_frame(input logic [7:0] proto, input logic [15:0] sport,
                             input logic [15:0] dport, input int tunnels,
                             input int cut, input int pay);
    frame_bytes.delete();
    repeat (14) frame_bytes.push_back(8'($urandom));
    repeat (tunnels) begin
      for (int i = 0; i < 20; i++) frame_bytes.push_back(i == 9 ? PROTO_UDP : 8'($urandom));
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(TUNNEL_UDP_PORT[15:8]);
      frame_bytes.push_back(TUNNEL_UDP_PORT[7:0]);
      repeat (26) frame_bytes.push_back(8'($urandom));
    end
    for (int i = 0; i < 20; i++) frame_bytes.push_back(i == 9 ? proto : 8'($urandom));
    frame_bytes.push_back(sport[15:8]);
    frame_bytes.push_back(sport[7:0]);
    frame_bytes.push_back(dport[15:8]);
    frame_bytes.push_back(dport[7:0]);
    repeat (pay) frame_bytes.push_back(8'($urandom));
    if (cut > 0)
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  task automatic build_noise(input int len);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_port();
    if ($urandom_range(0, 1)) return table_entry($urandom_range(0, 9));
    return 16'($urandom);
  endfunction

  task automatic random_frame();
    int          kind;
    int          tunnels;
    int          cut;
    int          pay;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    kind    = $urandom_range(0, 99);
    tunnels = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) :
              (($urandom_range(0, 3) == 0) ? 1 : 0);
    proto   = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    sport   = pick_port();
    dport   = pick_port();
    pay     = $urandom_range(0, 6);
    cut     = 0;
    // udp to the vxlan port without a real tunnel behind it
    if (proto == PROTO_UDP && $urandom_range(0, 19) == 0) dport = TUNNEL_UDP_PORT;
    if (kind >= 60 && kind < 75) proto = 8'($urandom);
    else if (kind >= 75 && kind < 90) cut = $urandom_range(1, 38 + 50*tunnels + pay);
    if (kind >= 90) build_noise($urandom_range(1, 30));
    else build_frame(proto, sport, dport, tunnels, cut, pay);
    send_calm = ($urandom_range(0, 4) == 0);
    send_frame();
  endtask

  // receiver stops while short frames keep coming, so the input backs up
  task automatic pressure_burst();
    hold_req <= hold_req + 1;
    send_calm = 1'b1;
    repeat (24) begin
      build_noise($urandom_range(1, 2));
      send_frame();
    end
  endtask

  initial begin : stimulus
    int         base_bytes;
    int         n;
    frame_row_t row;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(64'd10, 64'h0016_FFFF_01BB_0050, 64'h1F90_0D3D_0035_0000,
               64'h0000_0000_2328_C350);
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      pin_q.push_back({row.fixed, row.hp, row.tr});
      build_frame(row.proto, row.sport, row.dport, row.tunnels, row.cut, row.pay);
      send_calm = ($urandom_range(0, 2) == 0);
      send_frame();
    end

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_config(64'd0, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        // count past the table size, all bits set
        2: set_config({64{1'b1}}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
        3: set_config(64'd10, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        4: set_config(64'($urandom_range(1, 9)), {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        default: set_config(64'hFFFF_FFFF_FFFF_FFF4, 64'd0, 64'd0, 64'hFFFF_FFFF_0000_0000);
      endcase
      base_bytes = parsed_bytes;
      n = 0;
      while (parsed_bytes - base_bytes < PHASE_BYTES) begin
        random_frame();
        n++;
        if (ph == 4 && n == 1) pressure_burst();
      end
    end

    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### l4_port_priority_classifier_unit.f
hw/rtl/l4pc_pkg.sv
hw/rtl/l4pc_port_match.sv
hw/rtl/l4pc_parser.sv
hw/rtl/l4_port_priority_classifier_unit.sv
tb/sv/tb_l4_port_priority_classifier_unit.sv
